/* rtl/tgcm_pkg.sv */
package tgcm_pkg;

	localparam int COL_W = 64;
	localparam int HGT_W = 7;
	localparam int NUM_LANES = 8;
	localparam int LANE_W = COL_W / NUM_LANES;
	localparam int LANE_CNT_W = $clog2(LANE_W + 1);
	localparam int SUM_W = $clog2(COL_W + 1);
	localparam int PROD_W = SUM_W + 4;
	localparam int JOB_DEPTH = 4;
	localparam int PTR_W = $clog2(JOB_DEPTH);
	localparam int CNT_W = $clog2(JOB_DEPTH + 1);

	typedef struct packed {
		logic [LANE_CNT_W-1:0] cur;
		logic [LANE_CNT_W-1:0] prv;
		logic [LANE_CNT_W-1:0] nxt;
	} lane_cnt_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [HGT_W-1:0] height;
		logic [COL_W-1:0] nxt;
		logic             strip_end;
	} job_t;

	function automatic logic [COL_W-1:0] row_mask(input logic [HGT_W-1:0] h);
		logic [COL_W-1:0] m;
		if (h >= HGT_W'(COL_W)) begin
			m = '1;
		end else begin
			m = (COL_W'(1) << h) - COL_W'(1);
		end
		return m;
	endfunction

endpackage

/* rtl/tgcm_lane.sv */
module tgcm_lane (
	input  logic [tgcm_pkg::LANE_W-1:0] cur_bits,
	input  logic [tgcm_pkg::LANE_W-1:0] prv_bits,
	input  logic [tgcm_pkg::LANE_W-1:0] nxt_bits,
	output tgcm_pkg::lane_cnt_t         cnt
);
	import tgcm_pkg::*;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < LANE_W; i++) begin
			cnt.cur = cnt.cur + LANE_CNT_W'(cur_bits[i]);
			cnt.prv = cnt.prv + LANE_CNT_W'(prv_bits[i]);
			cnt.nxt = cnt.nxt + LANE_CNT_W'(nxt_bits[i]);
		end
	end

endmodule

/* rtl/tgcm_merge.sv */
module tgcm_merge (
	input  tgcm_pkg::lane_cnt_t          lane_cnt [tgcm_pkg::NUM_LANES],
	input  logic [tgcm_pkg::HGT_W-1:0]   height,
	input  logic                         top_pixel,
	output logic                         fill
);
	import tgcm_pkg::*;

	logic [SUM_W-1:0]  cur_sum;
	logic [SUM_W-1:0]  prv_sum;
	logic [SUM_W-1:0]  nxt_sum;
	logic [PROD_W-1:0] cur_x10;
	logic [SUM_W-1:0]  h_ext;

	always_comb begin
		cur_sum = '0;
		prv_sum = '0;
		nxt_sum = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			cur_sum = cur_sum + SUM_W'(lane_cnt[i].cur);
			prv_sum = prv_sum + SUM_W'(lane_cnt[i].prv);
			nxt_sum = nxt_sum + SUM_W'(lane_cnt[i].nxt);
		end
	end

	assign cur_x10 = (PROD_W'(cur_sum) << 3) + (PROD_W'(cur_sum) << 1);
	assign h_ext   = SUM_W'(height);

	// narrow column, previous not solid, and a stroke on either side
	assign fill = (height != '0)
		&& !top_pixel
		&& (cur_x10 < PROD_W'(height))
		&& (prv_sum != h_ext)
		&& ((prv_sum != '0) || ((nxt_sum != '0) && (nxt_sum != h_ext)));

endmodule

/* rtl/text_gap_column_marker.sv */
// text_gap_column_marker
// Marks narrow gap columns in a binarized text-line strip so that later
// segmentation sees them as separators.
// Input channel s_axis: one pixel column per transfer, strip height in
// tdata, tlast on the final column of the strip.
// Output channel m_axis: one transfer per input column, in column order,
// tdata the column after marking, tuser set when it was filled as a gap,
// tlast on the final column.
// A column is held until the next one arrives, so its result follows the
// next input transfer; the final column of a strip comes out with it.
// The transfer that releases a result writes the job queue; the decision
// stage registers the head's result onto m_axis. Throughput is one column per
// cycle while nothing stalls: the decision stage, with its eight popcount lanes
// and the feedback of the previous result column, handles one column each
// cycle. A tlast transfer after a held column releases two results; the
// four-entry job queue absorbs them and s_axis_tready drops while fewer than
// two entries are free. When m_axis_tready is low the output register holds and
// the queue fills, then s_axis_tready falls. Reset empties the queue, the held
// column and the previous-column state; no strip is in progress after reset.
module text_gap_column_marker #(
	parameter int MAX_STRIP_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // column_pixels[63:0], strip_height[70:64], zero
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // out_pixels[63:0]
	output logic        m_axis_tuser,  // was_filled[0]
	output logic        m_axis_tlast
);
	import tgcm_pkg::*;

	logic             in_xfer;
	logic [COL_W-1:0] in_col;
	logic [HGT_W-1:0] in_h_raw;
	logic [HGT_W-1:0] in_h;

	logic [COL_W-1:0] held_col_q;
	logic [HGT_W-1:0] held_h_q;
	logic             held_valid_q;

	job_t             job_q [JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr_one;
	logic             wr_two;
	job_t             job_first;
	job_t             job_last;
	logic [CNT_W-1:0] n_wr;
	logic             pop;
	job_t             head;

	logic [COL_W-1:0] prior_q;
	logic [COL_W-1:0] mask;
	logic [COL_W-1:0] cur_m;
	logic [COL_W-1:0] prv_m;
	logic [COL_W-1:0] nxt_m;
	lane_cnt_t        lane_cnt [NUM_LANES];
	logic             fill;
	logic [COL_W-1:0] result;

	logic             out_valid_q;
	logic [COL_W-1:0] out_data_q;
	logic             out_fill_q;
	logic             out_end_q;

	assign in_col   = s_axis_tdata[COL_W-1:0];
	assign in_h_raw = s_axis_tdata[COL_W+HGT_W-1:COL_W];
	assign in_h     = (in_h_raw > HGT_W'(MAX_STRIP_HEIGHT)) ? HGT_W'(MAX_STRIP_HEIGHT)
		: in_h_raw;

	assign s_axis_tready = (cnt_q <= CNT_W'(JOB_DEPTH - 2));
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// held column is decided with the incoming one as its neighbor
	assign job_first.col       = held_valid_q ? held_col_q : in_col;
	assign job_first.height    = held_valid_q ? held_h_q : in_h;
	assign job_first.nxt       = held_valid_q ? in_col : '0;
	assign job_first.strip_end = !held_valid_q;
	assign job_last.col        = in_col;
	assign job_last.height     = in_h;
	assign job_last.nxt        = '0;
	assign job_last.strip_end  = 1'b1;

	assign wr_one = in_xfer && (held_valid_q || s_axis_tlast);
	assign wr_two = in_xfer && held_valid_q && s_axis_tlast;
	assign n_wr   = CNT_W'(wr_one) + CNT_W'(wr_two);

	assign head = job_q[rd_ptr_q];
	assign pop  = (cnt_q != '0) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (wr_one) begin
			job_q[wr_ptr_q] <= job_first;
		end
		if (wr_two) begin
			job_q[wr_ptr_q + PTR_W'(1)] <= job_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			cnt_q        <= '0;
			held_valid_q <= 1'b0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_wr);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_q + n_wr - CNT_W'(pop);
			if (in_xfer) begin
				held_valid_q <= !s_axis_tlast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && !s_axis_tlast) begin
			held_col_q <= in_col;
			held_h_q   <= in_h;
		end
	end

	assign mask  = row_mask(head.height);
	assign cur_m = head.col & mask;
	assign prv_m = prior_q & mask;
	assign nxt_m = head.nxt & mask;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		tgcm_lane u_lane (
			.cur_bits (cur_m[g*LANE_W +: LANE_W]),
			.prv_bits (prv_m[g*LANE_W +: LANE_W]),
			.nxt_bits (nxt_m[g*LANE_W +: LANE_W]),
			.cnt      (lane_cnt[g])
		);
	end

	tgcm_merge u_merge (
		.lane_cnt  (lane_cnt),
		.height    (head.height),
		.top_pixel (cur_m[0]),
		.fill      (fill)
	);

	assign result = fill ? mask : cur_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				prior_q     <= head.strip_end ? '0 : result;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= result;
			out_fill_q <= fill;
			out_end_q  <= head.strip_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_fill_q;
	assign m_axis_tlast  = out_end_q;

endmodule
